/* hdl/spq_pkg.sv */
package spq_pkg;

  localparam int unsigned CfgW          = 5;
  localparam int unsigned FreeW         = 5;
  localparam int unsigned ReqW          = 2;
  localparam int unsigned StatW         = 2;
  localparam int unsigned DefDepth      = 16;
  localparam int unsigned DefKeyW       = 16;
  localparam int unsigned DefPayloadW   = 32;
  localparam logic [CfgW-1:0] CapReset  = 5'd16;

  typedef enum logic [ReqW-1:0] {
    REQ_PUSH = 2'd0,
    REQ_POP  = 2'd1,
    REQ_PEEK = 2'd2,
    REQ_NOP  = 2'd3
  } req_e;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic push;   // insert new entry in key order
    logic pop;    // shift chain toward the head
  } cell_op_t;

endpackage

/* hdl/spq_cell.sv */
module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned KEY_WIDTH     = DefKeyW,
  parameter int unsigned PAYLOAD_WIDTH = DefPayloadW
) (
  input  logic                     clk_i,
  input  cell_op_t                 op_i,
  input  logic                     occupied_i,
  input  logic [KEY_WIDTH-1:0]     new_key_i,
  input  logic [PAYLOAD_WIDTH-1:0] new_payload_i,
  input  logic                     left_ge_i,
  input  logic [KEY_WIDTH-1:0]     left_key_i,
  input  logic [PAYLOAD_WIDTH-1:0] left_payload_i,
  input  logic [KEY_WIDTH-1:0]     right_key_i,
  input  logic [PAYLOAD_WIDTH-1:0] right_payload_i,
  output logic                     ge_o,
  output logic [KEY_WIDTH-1:0]     key_o,
  output logic [PAYLOAD_WIDTH-1:0] payload_o
);

  logic [KEY_WIDTH-1:0]     key_q, key_d;
  logic [PAYLOAD_WIDTH-1:0] payload_q, payload_d;

  // ge stays set for the leading run of entries that outrank or tie the new key
  assign ge_o = occupied_i && (key_q >= new_key_i);

  always_comb begin
    key_d     = key_q;
    payload_d = payload_q;
    if (op_i.push) begin
      if (!ge_o) begin
        if (left_ge_i) begin
          key_d     = new_key_i;
          payload_d = new_payload_i;
        end else begin
          key_d     = left_key_i;
          payload_d = left_payload_i;
        end
      end
    end else if (op_i.pop) begin
      key_d     = right_key_i;
      payload_d = right_payload_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    payload_q <= payload_d;
  end

  assign key_o     = key_q;
  assign payload_o = payload_q;

endmodule

/* hdl/sorted_priority_queue.sv */
// Sorted priority queue built as a chain of compare-and-shift cells.
// Requests arrive on the s_axis channel: tuser carries the request kind
// (push, pop, peek), tdata the key and payload of a push. Each accepted
// beat yields exactly one result beat on m_axis: tuser is the status
// (ok, full, empty), tdata the head key and payload for a successful pop
// or peek (zero otherwise), the free slot count and the empty flag.
// The cfg channel writes the capacity register; it is always ready. The user
// must see that it is written only while the queue is quiet; the block itself
// does not enforce it. The result is registered in the cycle after a request
// is accepted. Every cell compares the new key against its own entry in the
// same cycle and takes its neighbor's entry, so one request is taken per
// cycle, bounded only by the result register draining. While the result
// register is full and m_axis_tready is low, s_axis_tready is low and the
// queue holds. Reset empties the queue and sets the capacity to 16; cell
// contents are not cleared, as only occupied cells are ever read.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH         = DefDepth,
  parameter int unsigned KEY_WIDTH     = DefKeyW,
  parameter int unsigned PAYLOAD_WIDTH = DefPayloadW
) (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgW-1:0]     cfg_data_i,

  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // lsb up: priority_key, payload, zero fill
  input  logic [((KEY_WIDTH + PAYLOAD_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // req_type
  input  logic [ReqW-1:0]     s_axis_tuser,

  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // lsb up: out_key, out_payload, free_slots, is_empty, zero fill
  output logic [((KEY_WIDTH + PAYLOAD_WIDTH + FreeW + 1 + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // status
  output logic [StatW-1:0]    m_axis_tuser
);

  localparam int unsigned InRawW   = KEY_WIDTH + PAYLOAD_WIDTH;
  localparam int unsigned InDataW  = ((InRawW + 7) / 8) * 8;
  localparam int unsigned OutRawW  = KEY_WIDTH + PAYLOAD_WIDTH + FreeW + 1;
  localparam int unsigned OutDataW = ((OutRawW + 7) / 8) * 8;
  localparam int unsigned CntW     = $clog2(DEPTH + 1);
  localparam int unsigned CW       = (CntW > CfgW) ? CntW : CfgW;

  logic [CfgW-1:0] cap_q;
  logic [CntW-1:0] count_q, count_d;

  logic                     out_valid_q;
  status_e                  out_status_q, status_c;
  logic [KEY_WIDTH-1:0]     out_key_q, okey_c;
  logic [PAYLOAD_WIDTH-1:0] out_pay_q, opay_c;
  logic [FreeW-1:0]         out_free_q, free_c;
  logic                     out_empty_q;

  logic                     in_fire;
  req_e                     req;
  logic [KEY_WIDTH-1:0]     in_key;
  logic [PAYLOAD_WIDTH-1:0] in_pay;
  logic [CW-1:0]            eff_cap, count_ext, countn_ext;
  logic                     push_ok, head_ok;
  cell_op_t                 op;

  logic [KEY_WIDTH-1:0]     cell_key [DEPTH];
  logic [PAYLOAD_WIDTH-1:0] cell_pay [DEPTH];
  logic [DEPTH-1:0]         cell_ge;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign req    = req_e'(s_axis_tuser);
  assign in_key = s_axis_tdata[KEY_WIDTH-1:0];
  assign in_pay = s_axis_tdata[KEY_WIDTH +: PAYLOAD_WIDTH];

  // capacity clamped to 1..DEPTH
  always_comb begin
    eff_cap = CW'(cap_q);
    if (eff_cap == '0) begin
      eff_cap = CW'(1);
    end else if (eff_cap > CW'(DEPTH)) begin
      eff_cap = CW'(DEPTH);
    end
  end

  assign count_ext = CW'(count_q);
  assign push_ok   = (count_ext < eff_cap);
  assign head_ok   = (count_q != '0);

  always_comb begin
    op        = '0;
    count_d   = count_q;
    status_c  = ST_OK;
    okey_c    = '0;
    opay_c    = '0;
    case (req)
      REQ_PUSH: begin
        if (push_ok) begin
          op.push = in_fire;
          count_d = count_q + CntW'(1);
        end else begin
          status_c = ST_FULL;
        end
      end
      REQ_POP, REQ_PEEK: begin
        if (head_ok) begin
          okey_c = cell_key[0];
          opay_c = cell_pay[0];
          if (req == REQ_POP) begin
            op.pop  = in_fire;
            count_d = count_q - CntW'(1);
          end
        end else begin
          status_c = ST_EMPTY;
        end
      end
      default: begin
      end
    endcase
  end

  assign countn_ext = CW'(count_d);
  assign free_c     = (eff_cap > countn_ext) ? FreeW'(eff_cap - countn_ext) : '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                     left_ge;
    logic [KEY_WIDTH-1:0]     left_key, right_key;
    logic [PAYLOAD_WIDTH-1:0] left_pay, right_pay;
    logic                     occ;

    assign occ = (CW'(g) < count_ext);

    if (g == 0) begin : g_head
      assign left_ge  = 1'b1;
      assign left_key = in_key;
      assign left_pay = in_pay;
    end else begin : g_body
      assign left_ge  = cell_ge[g-1];
      assign left_key = cell_key[g-1];
      assign left_pay = cell_pay[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_key = cell_key[g];
      assign right_pay = cell_pay[g];
    end else begin : g_mid
      assign right_key = cell_key[g+1];
      assign right_pay = cell_pay[g+1];
    end

    spq_cell #(
      .KEY_WIDTH     (KEY_WIDTH),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_cell (
      .clk_i           (clk_i),
      .op_i            (op),
      .occupied_i      (occ),
      .new_key_i       (in_key),
      .new_payload_i   (in_pay),
      .left_ge_i       (left_ge),
      .left_key_i      (left_key),
      .left_payload_i  (left_pay),
      .right_key_i     (right_key),
      .right_payload_i (right_pay),
      .ge_o            (cell_ge[g]),
      .key_o           (cell_key[g]),
      .payload_o       (cell_pay[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CapReset;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (in_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_status_q <= status_c;
      out_key_q    <= okey_c;
      out_pay_q    <= opay_c;
      out_free_q   <= free_c;
      out_empty_q  <= (count_d == '0);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = OutDataW'({out_empty_q, out_free_q, out_pay_q, out_key_q});

  logic unused_in;
  assign unused_in = ^s_axis_tdata[InDataW-1 -: (InDataW - InRawW + 1)] ^ cell_ge[DEPTH-1];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(count_q) <= CW'(DEPTH))
    else $error("entry count above depth");

  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && req == REQ_PUSH && !push_ok) |=> $stable(count_q))
    else $error("refused push changed count");

  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && req == REQ_POP && head_ok) |=> (count_q == $past(count_q) - CntW'(1)))
    else $error("pop did not remove one entry");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == ST_EMPTY) |-> (out_key_q == '0 && out_empty_q))
    else $error("empty result carries data");

endmodule
